// File: hw/rtl/oat_pkg.sv
// Shared types, constants and command/status bundles for the ordered array table.
package oat_pkg;

  localparam int DEPTH  = 256;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_FIND   = 3'd4,
    OP_GET    = 3'd5,
    OP_SET    = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                      operation;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture index and value of the item
    logic    wr_in_cnt;   // write item value at the fill count (push)
    logic    wr_in_idx;   // write item value at item index (set, append)
    logic    rd_in_idx;   // read entry at item index (get)
    logic    move_start;  // set up a shift pass
    logic    up;          // shift direction: 1 insert, 0 erase
    logic    find_start;  // set up a scan pass
    logic    step;        // advance the pass by one read
    logic    shift_wr;    // write back the entry read last cycle
    logic    fill;        // write stored value at stored index
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    respond;
    status_t rsp_status;
    logic    rsp_get;
    logic    rsp_find;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_gt_cnt;
    logic idx_ge_cnt;
    logic idx_eq_cnt;
    logic pass_done;
    logic hit;
  } stat_t;

endpackage

// File: hw/rtl/oat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/oat_dp.sv
// Datapath: entry RAM, fill count, shift/scan pointers, compare and result register.
module oat_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  oat_pkg::in_item_t in_item,
  input  oat_pkg::cmd_t     cmd,
  output oat_pkg::stat_t    stat,
  output logic              out_valid,
  output oat_pkg::out_item_t out_item
);

  logic [oat_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [oat_pkg::AW-1:0]     idx_r, idx_nxt;
  logic [oat_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [oat_pkg::AW-1:0]     ptr_r, ptr_nxt;
  logic [oat_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic                       pend_r, pend_nxt;
  logic [oat_pkg::AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic                       up_r, up_nxt;
  logic                       out_valid_r;
  oat_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [oat_pkg::CNT_W-1:0]  in_idx_c;
  logic                       we;
  logic [oat_pkg::AW-1:0]     waddr;
  logic [oat_pkg::DATA_W-1:0] wdata;
  logic                       re;
  logic [oat_pkg::AW-1:0]     raddr;
  logic [oat_pkg::DATA_W-1:0] rdata;

  assign in_idx_c = oat_pkg::CNT_W'(in_item.index);

  assign stat.empty      = (cnt_r == '0);
  assign stat.full       = (cnt_r >= oat_pkg::CNT_W'(oat_pkg::DEPTH));
  assign stat.idx_gt_cnt = (in_idx_c > cnt_r);
  assign stat.idx_ge_cnt = (in_idx_c >= cnt_r);
  assign stat.idx_eq_cnt = (in_idx_c == cnt_r);
  assign stat.pass_done  = (rem_r == '0) && !pend_r;
  assign stat.hit        = pend_r && (rdata == val_r);

  always_comb begin
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    up_nxt        = up_r;
    cnt_nxt       = cnt_r;

    if (cmd.load) begin
      idx_nxt = oat_pkg::AW'(in_item.index);
      val_nxt = in_item.value;
    end
    if (cmd.move_start) begin
      up_nxt   = cmd.up;
      pend_nxt = 1'b0;
      if (cmd.up) begin
        ptr_nxt = oat_pkg::AW'(cnt_r - 1'b1);
        rem_nxt = cnt_r - in_idx_c;
      end else begin
        ptr_nxt = oat_pkg::AW'(in_idx_c + 1'b1);
        rem_nxt = cnt_r - in_idx_c - 1'b1;
      end
    end
    if (cmd.find_start) begin
      up_nxt   = 1'b0;
      pend_nxt = 1'b0;
      ptr_nxt  = '0;
      rem_nxt  = cnt_r;
    end
    if (cmd.step) begin
      pend_nxt = (rem_r != '0);
      if (rem_r != '0) begin
        ptr_nxt       = up_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
        rem_nxt       = rem_r - 1'b1;
        pend_addr_nxt = ptr_r;
      end
    end

    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // RAM port steering
  always_comb begin
    re    = cmd.rd_in_idx || (cmd.step && (rem_r != '0));
    raddr = cmd.rd_in_idx ? oat_pkg::AW'(in_item.index) : ptr_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.wr_in_cnt) begin
      we    = 1'b1;
      waddr = oat_pkg::AW'(cnt_r);
      wdata = in_item.value;
    end else if (cmd.wr_in_idx) begin
      we    = 1'b1;
      waddr = oat_pkg::AW'(in_item.index);
      wdata = in_item.value;
    end else if (cmd.fill) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = val_r;
    end else if (cmd.shift_wr && pend_r) begin
      we    = 1'b1;
      waddr = up_r ? pend_addr_r + 1'b1 : pend_addr_r - 1'b1;
      wdata = rdata;
    end
  end

  oat_ram #(
    .WIDTH(oat_pkg::DATA_W),
    .DEPTH(oat_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    out_item_nxt.status      = cmd.rsp_status;
    out_item_nxt.read_value  = cmd.rsp_get ? rdata : '0;
    out_item_nxt.found       = cmd.rsp_find;
    out_item_nxt.found_index = cmd.rsp_find ? oat_pkg::IDX_W'(pend_addr_r) : '0;
    out_item_nxt.count       = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    up_r        <= up_nxt;
    if (cmd.respond) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: hw/rtl/oat_ctrl.sv
// Controller: decodes each item and sequences get, shift and scan passes.
module oat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  oat_pkg::in_item_t in_item,
  input  oat_pkg::stat_t    stat,
  output logic              busy,
  output oat_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FIND
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.operation)
            oat_pkg::OP_PUSH: begin
              cmd.respond = 1'b1;
              if (stat.full) begin
                cmd.rsp_status = oat_pkg::ST_FULL;
              end else begin
                cmd.wr_in_cnt = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end
            end
            oat_pkg::OP_POP: begin
              cmd.respond = 1'b1;
              if (stat.empty) begin
                cmd.rsp_status = oat_pkg::ST_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            oat_pkg::OP_INSERT: begin
              if (stat.idx_gt_cnt) begin
                cmd.respond    = 1'b1;
                cmd.rsp_status = oat_pkg::ST_RANGE;
              end else if (stat.full) begin
                cmd.respond    = 1'b1;
                cmd.rsp_status = oat_pkg::ST_FULL;
              end else if (stat.idx_eq_cnt) begin
                cmd.respond   = 1'b1;
                cmd.wr_in_idx = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end else begin
                cmd.load       = 1'b1;
                cmd.move_start = 1'b1;
                cmd.up         = 1'b1;
                state_nxt      = S_SHIFT_UP;
              end
            end
            oat_pkg::OP_ERASE: begin
              if (stat.idx_ge_cnt) begin
                cmd.respond    = 1'b1;
                cmd.rsp_status = oat_pkg::ST_RANGE;
              end else begin
                cmd.load       = 1'b1;
                cmd.move_start = 1'b1;
                state_nxt      = S_SHIFT_DN;
              end
            end
            oat_pkg::OP_FIND: begin
              if (stat.empty) begin
                cmd.respond = 1'b1;
              end else begin
                cmd.load       = 1'b1;
                cmd.find_start = 1'b1;
                state_nxt      = S_FIND;
              end
            end
            oat_pkg::OP_GET: begin
              if (stat.idx_ge_cnt) begin
                cmd.respond    = 1'b1;
                cmd.rsp_status = oat_pkg::ST_RANGE;
              end else begin
                cmd.rd_in_idx = 1'b1;
                state_nxt     = S_GET;
              end
            end
            oat_pkg::OP_SET: begin
              cmd.respond = 1'b1;
              if (stat.idx_ge_cnt) begin
                cmd.rsp_status = oat_pkg::ST_RANGE;
              end else begin
                cmd.wr_in_idx = 1'b1;
              end
            end
            default: begin
              cmd.respond = 1'b1;
              cmd.cnt_clr = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        cmd.respond = 1'b1;
        cmd.rsp_get = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SHIFT_UP: begin
        if (stat.pass_done) begin
          cmd.fill    = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      S_SHIFT_DN: begin
        if (stat.pass_done) begin
          cmd.cnt_dec = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      S_FIND: begin
        if (stat.hit) begin
          cmd.respond  = 1'b1;
          cmd.rsp_find = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.pass_done) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: hw/rtl/ordered_array_table.sv
// Top level of the ordered array table: controller, datapath and checks.
//
// Usage
//   An item (operation, index, value on in_item) is taken at a rising edge
//   with start high and busy low. Exactly one result comes back for each
//   item: out_valid is high for one cycle with out_item holding status,
//   read value, found flag, found index and the count after the operation.
//   The receiver cannot stall; a result must be taken in its cycle.
// Sequencing, n = count, i = index:
//   push, pop, set, clear, append, every error case, find on empty: no pass
//   get: one RAM read; find: scan pass from 0 that stops at the first match
//   insert before the end: shift pass moving entries n-1 down to i up one,
//   then the new value written at i; erase: entries above i moved down one
//   The passes go through the one entry RAM, one read a cycle (and one write
//   a cycle in a shift pass), with registered read data.
// Throughput: one item at a time; busy is high from the accept edge until
//   the result cycle, and a new item can be taken in the result cycle.
// Reset: synchronous, active low; the count is cleared. Entry contents are
//   not cleared: only places below the count are ever read.
module ordered_array_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oat_pkg::in_item_t  in_item,
  output logic               out_valid,
  output oat_pkg::out_item_t out_item
);

  oat_pkg::cmd_t  cmd;
  oat_pkg::stat_t stat;

  // item decode and pass sequencing
  oat_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_item(in_item),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // entry storage, count and result register
  oat_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // count never runs past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.count <= oat_pkg::CNT_W'(oat_pkg::DEPTH)))
    else $error("result count above depth");

  // full is only reported at depth, empty only at zero
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == oat_pkg::ST_FULL))
      |-> (out_item.count == oat_pkg::CNT_W'(oat_pkg::DEPTH)))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == oat_pkg::ST_EMPTY)) |-> (out_item.count == '0))
    else $error("empty status with nonzero count");

  // a match lies below the count
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found)
      |-> ((oat_pkg::CNT_W'(out_item.found_index) < out_item.count)
           && (out_item.status == oat_pkg::ST_OK)))
    else $error("found index outside the filled range");

  // no result while idle unless an item was taken the cycle before
  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(busy)) |-> $past(start))
    else $error("result without an item");

endmodule

// File: dv/tb_ordered_array_table.sv
// Self-checking testbench for ordered_array_table: directed and random items, shadow array.
module tb_ordered_array_table;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps a shadow copy of the array and fill count, predicts the
  // result of every accepted item and checks results in order.
  class array_scoreboard;
    logic signed [oat_pkg::DATA_W-1:0] shadow [oat_pkg::DEPTH];
    int                 fill;
    oat_pkg::out_item_t expected_q [$];
    oat_pkg::op_t       op_q [$];
    int                 errors;
    int                 checked;
    int                 op_seen [8];
    int                 status_seen [4];

    function new();
      fill    = 0;
      errors  = 0;
      checked = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(oat_pkg::in_item_t it);
      oat_pkg::out_item_t r;
      int idx;
      int i;
      r        = '0;
      r.status = oat_pkg::ST_OK;
      idx      = int'(it.index);
      case (it.operation)
        oat_pkg::OP_PUSH: begin
          if (fill >= oat_pkg::DEPTH) begin
            r.status = oat_pkg::ST_FULL;
          end else begin
            shadow[fill] = it.value;
            fill++;
          end
        end
        oat_pkg::OP_POP: begin
          if (fill == 0) r.status = oat_pkg::ST_EMPTY;
          else fill--;
        end
        oat_pkg::OP_INSERT: begin
          if (idx > fill) begin
            r.status = oat_pkg::ST_RANGE;
          end else if (fill >= oat_pkg::DEPTH) begin
            r.status = oat_pkg::ST_FULL;
          end else begin
            for (i = fill; i > idx; i--) shadow[i] = shadow[i-1];
            shadow[idx] = it.value;
            fill++;
          end
        end
        oat_pkg::OP_ERASE: begin
          if (idx >= fill) begin
            r.status = oat_pkg::ST_RANGE;
          end else begin
            for (i = idx; i + 1 < fill; i++) shadow[i] = shadow[i+1];
            fill--;
          end
        end
        oat_pkg::OP_FIND: begin
          for (i = 0; i < fill; i++) begin
            if (shadow[i] == it.value) begin
              r.found       = 1'b1;
              r.found_index = oat_pkg::IDX_W'(i);
              break;
            end
          end
        end
        oat_pkg::OP_GET: begin
          if (idx >= fill) r.status = oat_pkg::ST_RANGE;
          else r.read_value = shadow[idx];
        end
        oat_pkg::OP_SET: begin
          if (idx >= fill) r.status = oat_pkg::ST_RANGE;
          else shadow[idx] = it.value;
        end
        default: fill = 0;  // clear keeps contents, hides them
      endcase
      r.count = oat_pkg::CNT_W'(fill);
      op_seen[int'(it.operation)]++;
      status_seen[int'(r.status)]++;
      expected_q.push_back(r);
      op_q.push_back(it.operation);
    endfunction

    function void check_result(oat_pkg::out_item_t got);
      oat_pkg::out_item_t want;
      oat_pkg::op_t       op;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] result with nothing expected: ",
                    "status=%0d rd=%0d found=%0d fidx=%0d cnt=%0d"},
                   $time, got.status, got.read_value, got.found, got.found_index, got.count);
        return;
      end
      want = expected_q.pop_front();
      op   = op_q.pop_front();
      checked++;
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found !== want.found || got.found_index !== want.found_index ||
          got.count !== want.count) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] mismatch on %s", $time, op.name());
          $display("  want: status=%0d rd=%0d found=%0d fidx=%0d cnt=%0d",
                   want.status, want.read_value, want.found, want.found_index, want.count);
          $display("  got : status=%0d rd=%0d found=%0d fidx=%0d cnt=%0d",
                   got.status, got.read_value, got.found, got.found_index, got.count);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  oat_pkg::in_item_t  in_item;
  logic               out_valid;
  oat_pkg::out_item_t out_item;

  array_scoreboard sb;
  int  sent;       // items accepted so far
  bit  gaps_on;    // sender inserts idle gaps between items

  ordered_array_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: results still pending");
    $display("** ordered_array_table: FAILED **");
    $finish;
  end

  // Sampling at the rising edge. The result of the previous item is checked
  // before the item taken in the same cycle is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_item(in_item);
    end
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Values: full random, a tiny pool so duplicates show up for find, and extremes.
  function automatic logic signed [oat_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 85) return oat_pkg::DATA_W'($signed($urandom_range(4)) - 2);
    if (r < 92) return {1'b1, {(oat_pkg::DATA_W-1){1'b0}}};
    return {1'b0, {(oat_pkg::DATA_W-1){1'b1}}};
  endfunction

  // Indexes: mostly legal for the operation, with the count boundary and
  // any 8-bit value mixed in.
  function automatic logic [oat_pkg::IDX_W-1:0] pick_index(oat_pkg::op_t op);
    int r;
    r = $urandom_range(99);
    if (r < 15) return oat_pkg::IDX_W'($urandom_range(255));
    if (r < 30) return oat_pkg::IDX_W'(sb.fill);
    if (op == oat_pkg::OP_INSERT) begin
      if (sb.fill > 255) return oat_pkg::IDX_W'($urandom_range(255));
      return oat_pkg::IDX_W'($urandom_range(sb.fill));
    end
    if (sb.fill == 0) return oat_pkg::IDX_W'($urandom_range(255));
    return oat_pkg::IDX_W'($urandom_range(sb.fill - 1));
  endfunction

  // Drive one item from a falling edge and hold it until taken. Returns at
  // the falling edge after acceptance, possibly after an idle gap.
  task automatic send_item(input oat_pkg::op_t op, input logic [oat_pkg::IDX_W-1:0] idx,
                           input logic signed [oat_pkg::DATA_W-1:0] val);
    int gap;
    in_item.operation = op;
    in_item.index     = idx;
    in_item.value     = val;
    start             = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_for_results();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    oat_pkg::op_t op;
    logic signed [oat_pkg::DATA_W-1:0] val;
    r = $urandom_range(99);
    if (r < 18)      op = oat_pkg::OP_PUSH;
    else if (r < 30) op = oat_pkg::OP_POP;
    else if (r < 48) op = oat_pkg::OP_INSERT;
    else if (r < 60) op = oat_pkg::OP_ERASE;
    else if (r < 74) op = oat_pkg::OP_FIND;
    else if (r < 86) op = oat_pkg::OP_GET;
    else if (r < 96) op = oat_pkg::OP_SET;
    else             op = oat_pkg::OP_CLEAR;
    val = pick_value();
    // finds look for a value that is present half the time
    if (op == oat_pkg::OP_FIND && sb.fill > 0 && $urandom_range(1))
      val = sb.shadow[$urandom_range(sb.fill - 1)];
    send_item(op, pick_index(op), val);
  endtask

  task automatic churn(input int n);
    repeat (n) begin
      random_item();
      if ($urandom_range(99) < 3) wait_for_results();
    end
  endtask

  // Grow the array to full with appends and inserts near the end (short
  // shifts), a few deep inserts, and reads mixed in.
  task automatic fill_to_full();
    int r;
    int lo;
    while (sb.fill < oat_pkg::DEPTH) begin
      r  = $urandom_range(99);
      lo = (sb.fill > 8) ? sb.fill - 8 : 0;
      if (r < 55)
        send_item(oat_pkg::OP_PUSH, oat_pkg::IDX_W'($urandom_range(255)), pick_value());
      else if (r < 78)
        send_item(oat_pkg::OP_INSERT, oat_pkg::IDX_W'($urandom_range(sb.fill, lo)),
                  pick_value());
      else if (r < 82)
        send_item(oat_pkg::OP_INSERT, oat_pkg::IDX_W'($urandom_range(3)), pick_value());
      else if (r < 91 && sb.fill > 0)
        send_item(oat_pkg::OP_GET, oat_pkg::IDX_W'($urandom_range(sb.fill - 1)), $urandom);
      else if (sb.fill > 0)
        send_item(oat_pkg::OP_FIND, oat_pkg::IDX_W'($urandom_range(255)),
                  sb.shadow[$urandom_range(sb.fill - 1)]);
    end
  endtask

  initial begin
    sb        = new();
    sent      = 0;
    gaps_on   = 1'b1;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: every error path on an empty array, then small edits.
    send_item(oat_pkg::OP_POP,    8'd0,   32'sd0);             // empty
    send_item(oat_pkg::OP_ERASE,  8'd0,   32'sd0);             // range on empty
    send_item(oat_pkg::OP_GET,    8'd0,   32'sd0);
    send_item(oat_pkg::OP_SET,    8'd0,   32'sd7);
    send_item(oat_pkg::OP_FIND,   8'd0,   32'sd0);             // empty find, no match
    send_item(oat_pkg::OP_INSERT, 8'd1,   32'sd1);             // past the end
    send_item(oat_pkg::OP_INSERT, 8'd0,   {1'b1, 31'd0});      // append at count
    send_item(oat_pkg::OP_PUSH,   8'hff,  {1'b0, {31{1'b1}}});
    send_item(oat_pkg::OP_PUSH,   8'd0,   -32'sd1);
    send_item(oat_pkg::OP_PUSH,   8'd0,   32'sd0);
    send_item(oat_pkg::OP_INSERT, 8'd1,   32'sd5);             // shift up
    send_item(oat_pkg::OP_PUSH,   8'd0,   -32'sd1);            // duplicate for find
    send_item(oat_pkg::OP_FIND,   8'd0,   -32'sd1);            // first of two
    send_item(oat_pkg::OP_FIND,   8'd0,   32'sd12345);         // no match
    send_item(oat_pkg::OP_GET,    8'hff,  32'sd0);             // range
    send_item(oat_pkg::OP_GET,    8'd0,   32'sd0);
    send_item(oat_pkg::OP_SET,    8'd1,   32'sh5a5a_a5a5);
    send_item(oat_pkg::OP_GET,    8'd1,   32'sd0);
    send_item(oat_pkg::OP_ERASE,  8'd0,   32'sd0);             // shift down
    send_item(oat_pkg::OP_ERASE,  8'd4,   32'sd0);             // last entry
    send_item(oat_pkg::OP_INSERT, 8'hff,  32'sd0);             // range
    send_item(oat_pkg::OP_CLEAR,  8'hff,  -32'sd1);
    send_item(oat_pkg::OP_GET,    8'd0,   32'sd0);             // hidden after clear
    send_item(oat_pkg::OP_POP,    8'd0,   32'sd0);
    wait_for_results();

    // Random churn on small arrays with idle gaps.
    churn(200);
    wait_for_results();

    // Full array and its corners.
    fill_to_full();
    send_item(oat_pkg::OP_PUSH,   8'd0,   32'sd1);             // full
    send_item(oat_pkg::OP_INSERT, 8'd0,   32'sd1);             // full, valid index
    send_item(oat_pkg::OP_INSERT, 8'hff,  32'sd1);
    send_item(oat_pkg::OP_GET,    8'hff,  32'sd0);
    send_item(oat_pkg::OP_SET,    8'hff,  {1'b0, {31{1'b1}}});
    send_item(oat_pkg::OP_FIND,   8'd0,   {1'b0, {31{1'b1}}});
    send_item(oat_pkg::OP_FIND,   8'd0,   32'sh1357_9bdf);
    send_item(oat_pkg::OP_ERASE,  8'hff,  32'sd0);
    send_item(oat_pkg::OP_INSERT, 8'hff,  32'sd9);             // append back to full
    send_item(oat_pkg::OP_ERASE,  8'd0,   32'sd0);             // longest shift down
    send_item(oat_pkg::OP_INSERT, 8'd0,   32'sd3);             // longest shift up
    send_item(oat_pkg::OP_POP,    8'd0,   32'sd0);
    send_item(oat_pkg::OP_PUSH,   8'd0,   32'sd4);
    send_item(oat_pkg::OP_PUSH,   8'd0,   32'sd4);             // full again
    send_item(oat_pkg::OP_CLEAR,  8'd0,   32'sd0);
    send_item(oat_pkg::OP_GET,    8'd0,   32'sd0);
    wait_for_results();

    // Back-to-back stretch, then gaps again up to the item budget.
    gaps_on = 1'b0;
    churn(120);
    gaps_on = 1'b1;
    wait_for_results();
    while (sent < 750) churn(10);

    // Drain, then give any stray result time to show up.
    wait_for_results();
    repeat (300) @(negedge clk);

    $display({"Ran %0d items: push %0d pop %0d insert %0d erase %0d ",
              "find %0d get %0d set %0d clear %0d"},
             sent, sb.op_seen[oat_pkg::OP_PUSH], sb.op_seen[oat_pkg::OP_POP],
             sb.op_seen[oat_pkg::OP_INSERT], sb.op_seen[oat_pkg::OP_ERASE],
             sb.op_seen[oat_pkg::OP_FIND], sb.op_seen[oat_pkg::OP_GET],
             sb.op_seen[oat_pkg::OP_SET], sb.op_seen[oat_pkg::OP_CLEAR]);
    $display({"Checked %0d results: ok %0d, out of range %0d, empty %0d, ",
              "full %0d; %0d errors"},
             sb.checked, sb.status_seen[oat_pkg::ST_OK], sb.status_seen[oat_pkg::ST_RANGE],
             sb.status_seen[oat_pkg::ST_EMPTY], sb.status_seen[oat_pkg::ST_FULL], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** ordered_array_table: PASSED **");
    end else begin
      $display("** ordered_array_table: FAILED **");
    end
    $finish;
  end

endmodule
